// ----- src/gbp_pkg.sv -----
// Shared types and constants for the gradient bucket packer.
// No dependencies; used by gbp_front, gbp_back and gradient_bucket_packer.
package gbp_pkg;

  localparam int unsigned IndexW  = 16;
  localparam int unsigned GroupW  = 3;
  localparam int unsigned BytesW  = 40;
  localparam int unsigned CapW    = 41;
  localparam int unsigned BucketW = 16;

  localparam logic [CapW-1:0] FirstCapReset  = 41'd1048576;
  localparam logic [CapW-1:0] NormalCapReset = 41'd26214400;

  // configuration register indexes
  localparam logic RegFirstCap  = 1'b0;
  localparam logic RegNormalCap = 1'b1;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_FLUSH = 2'd2
  } gbp_kind_e;

  // tensor descriptor after group reduction
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [GroupW-1:0] group;
    logic [BytesW-1:0] bytes;
    logic              last;
  } gbp_item_t;

  typedef struct packed {
    gbp_kind_e          kind;
    logic [IndexW-1:0]  index;
    logic [GroupW-1:0]  group;
    logic [BucketW-1:0] bucket;
    logic               last;
  } gbp_rec_t;

endpackage

// ----- src/gradient_bucket_packer.sv -----
// Top level of the gradient bucket packer: front queue plus bucketing back end.
// Depends on gbp_pkg, gbp_front and gbp_back.
//
//   channel   direction  handshake          payload
//   tensor    in         push / full        tensor_index_i group_id_i byte_count_i
//                                           last_tensor_i
//   record    out        pop / empty        record_kind_o placed_index_o
//                                           placed_group_o bucket_number_o last_result_o
//   config    in         cfg_we_i           cfg_index_i cfg_data_i
//
// One tensor per cycle unless a waiting result or a flush walk stalls it: a single 41-bit add,
// saturate and cap compare per item. A last tensor that leaves a group open starts a
// flush walk over the groups seen (at most NUM_GROUPS); no tensor leaves the front
// queue meanwhile. Results sit in a one-word output register; pop low stalls the back
// end and then fills the QUEUE_DEPTH-word front queue. Reset clears totals, flags and
// counters; caps return to 1 MiB and 25 MiB. The end flush keeps the caps.
module gradient_bucket_packer #(
  parameter int unsigned NUM_GROUPS  = 8,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [gbp_pkg::IndexW-1:0]    tensor_index_i,
  input  logic [gbp_pkg::GroupW-1:0]    group_id_i,
  input  logic [gbp_pkg::BytesW-1:0]    byte_count_i,
  input  logic                          last_tensor_i,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    record_kind_o,
  output logic [gbp_pkg::IndexW-1:0]    placed_index_o,
  output logic [gbp_pkg::GroupW-1:0]    placed_group_o,
  output logic [gbp_pkg::BucketW-1:0]   bucket_number_o,
  output logic                          last_result_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [gbp_pkg::CapW-1:0]      cfg_data_i
);

  gbp_pkg::gbp_item_t item;
  logic               item_empty, item_pop;
  gbp_pkg::gbp_rec_t  rec;

  gbp_front #(
    .NUM_GROUPS (NUM_GROUPS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .tensor_index_i(tensor_index_i),
    .group_id_i    (group_id_i),
    .byte_count_i  (byte_count_i),
    .last_tensor_i (last_tensor_i),
    .item_pop_i    (item_pop),
    .item_o        (item),
    .item_empty_o  (item_empty)
  );

  gbp_back #(
    .NUM_GROUPS(NUM_GROUPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .rec_o       (rec)
  );

  assign record_kind_o   = rec.kind;
  assign placed_index_o  = rec.index;
  assign placed_group_o  = rec.group;
  assign bucket_number_o = rec.bucket;
  assign last_result_o   = rec.last;

endmodule

// ----- src/gbp_fifo.sv -----
// Small first-in first-out queue of raw words.
// No dependencies; instanced by gbp_front.
module gbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- src/gbp_front.sv -----
// Front end: takes tensor descriptors, folds the group id into range, queues them.
// Depends on gbp_pkg and gbp_fifo.
module gbp_front #(
  parameter int unsigned NUM_GROUPS  = 8,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [gbp_pkg::IndexW-1:0]     tensor_index_i,
  input  logic [gbp_pkg::GroupW-1:0]     group_id_i,
  input  logic [gbp_pkg::BytesW-1:0]     byte_count_i,
  input  logic                           last_tensor_i,
  input  logic                           item_pop_i,
  output gbp_pkg::gbp_item_t             item_o,
  output logic                           item_empty_o
);

  localparam int unsigned NumIds = 1 << gbp_pkg::GroupW;

  logic [gbp_pkg::GroupW-1:0] gmap [NumIds];
  gbp_pkg::gbp_item_t         item_in;
  logic [$bits(gbp_pkg::gbp_item_t)-1:0] head;

  // group id modulo group count, folded at elaboration into a lookup
  for (genvar v = 0; v < NumIds; v++) begin : g_map
    localparam int unsigned Reduced = v % NUM_GROUPS;
    assign gmap[v] = gbp_pkg::GroupW'(Reduced);
  end

  always_comb begin
    item_in.index = tensor_index_i;
    item_in.group = gmap[group_id_i];
    item_in.bytes = byte_count_i;
    item_in.last  = last_tensor_i;
  end

  gbp_fifo #(
    .WIDTH($bits(gbp_pkg::gbp_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item_in),
    .full_o (full_o),
    .pop_i  (item_pop_i),
    .data_o (head),
    .empty_o(item_empty_o)
  );

  assign item_o = gbp_pkg::gbp_item_t'(head);

endmodule

// ----- src/gbp_back.sv -----
// Back end: per-group byte totals, bucket closing, end flush walk, result register.
// Depends on gbp_pkg.
module gbp_back #(
  parameter int unsigned NUM_GROUPS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [gbp_pkg::CapW-1:0]     cfg_data_i,
  input  gbp_pkg::gbp_item_t           item_i,
  input  logic                         item_empty_i,
  output logic                         item_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output gbp_pkg::gbp_rec_t            rec_o
);

  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned CW = $clog2(NUM_GROUPS + 1);
  localparam int unsigned SW = gbp_pkg::CapW;

  logic [SW-1:0]         first_cap_q, normal_cap_q;
  logic [SW-1:0]         bytes_q [NUM_GROUPS];
  logic [SW-1:0]         bytes_d [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] nonempty_q, nonempty_d, past_q, past_d, seen_q, seen_d;
  logic [GW-1:0]         order_q [NUM_GROUPS];
  logic                  order_we;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [gbp_pkg::BucketW-1:0] bucket_q, bucket_d;
  logic                  flushing_q, flushing_d;
  logic [GW-1:0]         walk_q, walk_d;
  logic                  out_valid_q, out_valid_d;
  gbp_pkg::gbp_rec_t     out_q, out_d;

  logic                  adv, take, clear;
  logic [GW-1:0]         g, h;
  logic [SW:0]           sum_raw;
  logic [SW-1:0]         sum_sat, cap;
  logic                  close_now;
  logic [NUM_GROUPS-1:0] mask_after, mask_rest;

  assign adv        = !out_valid_q || pop_i;
  assign take       = adv && !flushing_q && !item_empty_i;
  assign item_pop_o = take;
  assign empty_o    = !out_valid_q;
  assign rec_o      = out_q;

  // placement path: one wide add, saturate, compare against the group's cap
  assign g       = GW'(item_i.group);
  assign sum_raw = {1'b0, bytes_q[g]} + (SW + 1)'(item_i.bytes);
  assign sum_sat = sum_raw[SW] ? {SW{1'b1}} : sum_raw[SW-1:0];
  assign cap     = past_q[g] ? normal_cap_q : first_cap_q;
  assign close_now = (sum_sat >= cap);

  always_comb begin
    mask_after    = nonempty_q;
    mask_after[g] = !close_now;
  end

  // flush walk path
  assign h         = order_q[walk_q];
  assign mask_rest = nonempty_q & ~(NUM_GROUPS'(1) << h);

  always_comb begin
    bytes_d     = bytes_q;
    nonempty_d  = nonempty_q;
    past_d      = past_q;
    seen_d      = seen_q;
    order_we    = 1'b0;
    cnt_d       = cnt_q;
    bucket_d    = bucket_q;
    flushing_d  = flushing_q;
    walk_d      = walk_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    clear       = 1'b0;

    if (take) begin
      if (!seen_q[g]) begin
        seen_d[g] = 1'b1;
        order_we  = 1'b1;
        cnt_d     = cnt_q + 1'b1;
      end
      out_valid_d  = 1'b1;
      out_d.index  = item_i.index;
      out_d.group  = item_i.group;
      out_d.last   = !item_i.last || (mask_after == '0);
      nonempty_d   = mask_after;
      if (close_now) begin
        out_d.kind   = gbp_pkg::KIND_CLOSE;
        out_d.bucket = bucket_q;
        bucket_d     = bucket_q + 1'b1;
        bytes_d[g]   = '0;
        past_d[g]    = 1'b1;
      end else begin
        out_d.kind   = gbp_pkg::KIND_OPEN;
        out_d.bucket = '0;
        bytes_d[g]   = sum_sat;
      end
      if (item_i.last) begin
        if (mask_after == '0) begin
          clear = 1'b1;
        end else begin
          flushing_d = 1'b1;
          walk_d     = '0;
        end
      end
    end else if (flushing_q && adv) begin
      walk_d = walk_q + 1'b1;
      if (nonempty_q[h]) begin
        out_valid_d   = 1'b1;
        out_d.kind    = gbp_pkg::KIND_FLUSH;
        out_d.index   = '0;
        out_d.group   = gbp_pkg::GroupW'(h);
        out_d.bucket  = bucket_q;
        out_d.last    = (mask_rest == '0);
        bucket_d      = bucket_q + 1'b1;
        bytes_d[h]    = '0;
        nonempty_d[h] = 1'b0;
        past_d[h]     = 1'b1;
        if (mask_rest == '0) begin
          clear      = 1'b1;
          flushing_d = 1'b0;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (adv) begin
      out_valid_d = 1'b0;
    end

    if (clear) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        bytes_d[i] = '0;
      end
      nonempty_d = '0;
      past_d     = '0;
      seen_d     = '0;
      cnt_d      = '0;
      bucket_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cap_q  <= gbp_pkg::FirstCapReset;
      normal_cap_q <= gbp_pkg::NormalCapReset;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        bytes_q[i] <= '0;
      end
      nonempty_q  <= '0;
      past_q      <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      bucket_q    <= '0;
      flushing_q  <= 1'b0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == gbp_pkg::RegFirstCap) begin
        first_cap_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == gbp_pkg::RegNormalCap) begin
        normal_cap_q <= cfg_data_i;
      end
      bytes_q     <= bytes_d;
      nonempty_q  <= nonempty_d;
      past_q      <= past_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      bucket_q    <= bucket_d;
      flushing_q  <= flushing_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (order_we) begin
      order_q[cnt_q[GW-1:0]] <= g;
    end
  end

endmodule
